// ===== rtl/core/rc4bc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4bc_pkg
// Shared types, constants and helper functions of the RC4 byte cipher core.
// ----------------------------------------------------------------------------
package rc4bc_pkg;

    // Byte and box geometry.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BOX_AW  = 8;
    localparam int unsigned BOX_DEPTH = 256;

    // Key length counter holds 0 up to KEY_MAX inclusive.
    localparam int unsigned KEY_CNT_W = 9;
    localparam logic [KEY_CNT_W-1:0] KEY_MAX = 9'd256;

    // Last box index, where the key schedule ends.
    localparam logic [BOX_AW-1:0] BOX_LAST = 8'hFF;

    // Bit-pair swap masks.
    localparam logic [BYTE_W-1:0] MASK_HI = 8'd170;
    localparam logic [BYTE_W-1:0] MASK_LO = 8'd85;

    // Cipher mode register codes.
    localparam logic [1:0] MODE_INVERT = 2'd0;
    localparam logic [1:0] MODE_SWAP   = 2'd1;
    localparam logic [1:0] MODE_RC4    = 2'd2;
    localparam logic [1:0] MODE_RESET  = MODE_RC4;

    // Command codes of an input request.
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // Access to the permutation box memory.
    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [BOX_AW-1:0] rd_addr;
        logic              wr_en;
        logic [BOX_AW-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
    } t_box_req;

    // Access to the key store memory.
    typedef struct packed {
        logic              rd_en;
        logic [BOX_AW-1:0] rd_addr;
        logic              wr_en;
        logic [BOX_AW-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
    } t_key_req;

    // Work handed from the top level to the sequencer.
    typedef struct packed {
        logic              key_start;
        logic              prga_start;
        logic              key_last;
        logic [BYTE_W-1:0] data_byte;
    } t_ctrl_cmd;

    // Status returned by the sequencer.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] out_byte;
    } t_ctrl_stat;

    // Swap each pair of adjacent bits.
    function automatic logic [BYTE_W-1:0] f_swap_pairs(input logic [BYTE_W-1:0] b);
        f_swap_pairs = ((b & MASK_HI) >> 1) | ((b & MASK_LO) << 1);
    endfunction

endpackage

// ===== rtl/core/rc4bc_box_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4bc_box_mem
// Permutation box: a 256 x 8 memory with one read and one write port and a
// registered read. Per-entry valid bits make unwritten entries read as zero
// after reset, or as their own index once a key schedule has cleared them.
// ----------------------------------------------------------------------------
module rc4bc_box_mem (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rc4bc_pkg::t_box_req                 i_req,
    output logic [rc4bc_pkg::BYTE_W-1:0]        o_rd_data
);

    logic [rc4bc_pkg::BYTE_W-1:0] mem [rc4bc_pkg::BOX_DEPTH];
    logic [rc4bc_pkg::BOX_DEPTH-1:0] r_valid;
    logic r_init;
    logic [rc4bc_pkg::BYTE_W-1:0] r_rd_raw;
    logic [rc4bc_pkg::BOX_AW-1:0] r_rd_addr;
    logic r_rd_hit;

    // Memory array: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_raw  <= mem[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
            r_rd_hit  <= r_valid[i_req.rd_addr];
        end
    end

    // Valid bits and the identity flag; a clear starts a fresh identity box.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_init  <= 1'b0;
        end else if (i_req.clear) begin
            r_valid <= '0;
            r_init  <= 1'b1;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // Entries never written since the last clear read as the base value.
    assign o_rd_data = r_rd_hit ? r_rd_raw : (r_init ? r_rd_addr : '0);

endmodule

// ===== rtl/core/rc4bc_key_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4bc_key_mem
// Key store: a 256 x 8 memory with one write and one registered read port.
// Its contents are undefined until written.
// ----------------------------------------------------------------------------
module rc4bc_key_mem (
    input  logic                                i_clk,
    input  rc4bc_pkg::t_key_req                 i_req,
    output logic [rc4bc_pkg::BYTE_W-1:0]        o_rd_data
);

    logic [rc4bc_pkg::BYTE_W-1:0] mem [rc4bc_pkg::BOX_DEPTH];
    logic [rc4bc_pkg::BYTE_W-1:0] r_rd_data;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/rc4bc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4bc_ctrl
// Sequencer for key loading, the key schedule and keystream generation.
// Every RC4 step is a read, read, write, write sequence on the box memory.
// ----------------------------------------------------------------------------
module rc4bc_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rc4bc_pkg::t_ctrl_cmd                i_cmd,
    input  logic                                i_out_free,
    input  logic [rc4bc_pkg::BYTE_W-1:0]        i_box_rd,
    input  logic [rc4bc_pkg::BYTE_W-1:0]        i_key_rd,
    output rc4bc_pkg::t_box_req                 o_box_req,
    output rc4bc_pkg::t_key_req                 o_key_req,
    output rc4bc_pkg::t_ctrl_stat               o_stat
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_KS_RD = 3'd1;
    localparam logic [2:0] ST_KS_J  = 3'd2;
    localparam logic [2:0] ST_KS_WA = 3'd3;
    localparam logic [2:0] ST_KS_WJ = 3'd4;
    localparam logic [2:0] ST_PG_RJ = 3'd5;
    localparam logic [2:0] ST_PG_WI = 3'd6;
    localparam logic [2:0] ST_PG_WJ = 3'd7;

    logic [2:0] r_state, n_state;
    logic [rc4bc_pkg::BOX_AW-1:0] r_first, n_first;
    logic [rc4bc_pkg::BOX_AW-1:0] r_second, n_second;
    logic [rc4bc_pkg::BOX_AW-1:0] r_kidx, n_kidx;
    logic [rc4bc_pkg::KEY_CNT_W-1:0] r_key_count, n_key_count;
    logic r_scheduled, n_scheduled;
    logic [rc4bc_pkg::BYTE_W-1:0] r_si, n_si;
    logic [rc4bc_pkg::BYTE_W-1:0] r_sj, n_sj;
    logic [rc4bc_pkg::BOX_AW-1:0] r_t, n_t;
    logic [rc4bc_pkg::BYTE_W-1:0] r_data, n_data;

    logic [rc4bc_pkg::KEY_CNT_W-1:0] key_eff;
    logic [rc4bc_pkg::KEY_CNT_W-1:0] key_n;
    logic [rc4bc_pkg::BOX_AW-1:0] ks_j;
    logic [rc4bc_pkg::BOX_AW-1:0] pg_j;
    logic [rc4bc_pkg::BYTE_W-1:0] ks_byte;

    // Key length as seen by a new key byte, and the modulus of the schedule.
    assign key_eff = r_scheduled ? '0 : r_key_count;
    assign key_n   = (r_key_count == '0) ? rc4bc_pkg::KEY_CNT_W'(1) : r_key_count;

    // Pointer sums of the schedule and of the keystream step.
    assign ks_j = r_second + i_box_rd + i_key_rd;
    assign pg_j = r_second + i_box_rd;

    // Keystream byte with forwarding of the swap that is still in flight.
    always_comb begin
        if (r_t == r_second) begin
            ks_byte = r_si;
        end else if (r_t == r_first) begin
            ks_byte = r_sj;
        end else begin
            ks_byte = i_box_rd;
        end
    end

    // Next state, memory requests and status.
    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        n_second    = r_second;
        n_kidx      = r_kidx;
        n_key_count = r_key_count;
        n_scheduled = r_scheduled;
        n_si        = r_si;
        n_sj        = r_sj;
        n_t         = r_t;
        n_data      = r_data;
        o_box_req   = '0;
        o_key_req   = '0;
        o_stat      = '0;
        o_stat.busy = (r_state != ST_IDLE);
        o_stat.out_byte = r_data ^ ks_byte;

        case (r_state)
            ST_IDLE: begin
                // Load a key byte; the last one starts the schedule.
                if (i_cmd.key_start) begin
                    n_scheduled = 1'b0;
                    n_key_count = key_eff;
                    if (key_eff < rc4bc_pkg::KEY_MAX) begin
                        o_key_req.wr_en   = 1'b1;
                        o_key_req.wr_addr = key_eff[rc4bc_pkg::BOX_AW-1:0];
                        o_key_req.wr_data = i_cmd.data_byte;
                        n_key_count = key_eff + rc4bc_pkg::KEY_CNT_W'(1);
                    end
                    if (i_cmd.key_last) begin
                        o_box_req.clear = 1'b1;
                        n_first  = '0;
                        n_second = '0;
                        n_kidx   = '0;
                        n_state  = ST_KS_RD;
                    end
                end
                // A keystream step starts by reading the advanced first pointer.
                if (i_cmd.prga_start) begin
                    n_first = r_first + rc4bc_pkg::BOX_AW'(1);
                    n_data  = i_cmd.data_byte;
                    o_box_req.rd_en   = 1'b1;
                    o_box_req.rd_addr = r_first + rc4bc_pkg::BOX_AW'(1);
                    n_state = ST_PG_RJ;
                end
            end
            ST_KS_RD: begin
                o_box_req.rd_en   = 1'b1;
                o_box_req.rd_addr = r_first;
                o_key_req.rd_en   = 1'b1;
                o_key_req.rd_addr = r_kidx;
                n_state = ST_KS_J;
            end
            ST_KS_J: begin
                n_si     = i_box_rd;
                n_second = ks_j;
                o_box_req.rd_en   = 1'b1;
                o_box_req.rd_addr = ks_j;
                n_state = ST_KS_WA;
            end
            ST_KS_WA: begin
                o_box_req.wr_en   = 1'b1;
                o_box_req.wr_addr = r_first;
                o_box_req.wr_data = i_box_rd;
                n_state = ST_KS_WJ;
            end
            ST_KS_WJ: begin
                o_box_req.wr_en   = 1'b1;
                o_box_req.wr_addr = r_second;
                o_box_req.wr_data = r_si;
                if ({1'b0, r_kidx} + rc4bc_pkg::KEY_CNT_W'(1) == key_n) begin
                    n_kidx = '0;
                end else begin
                    n_kidx = r_kidx + rc4bc_pkg::BOX_AW'(1);
                end
                if (r_first == rc4bc_pkg::BOX_LAST) begin
                    n_first     = '0;
                    n_second    = '0;
                    n_scheduled = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_first = r_first + rc4bc_pkg::BOX_AW'(1);
                    n_state = ST_KS_RD;
                end
            end
            ST_PG_RJ: begin
                n_si     = i_box_rd;
                n_second = pg_j;
                o_box_req.rd_en   = 1'b1;
                o_box_req.rd_addr = pg_j;
                n_state = ST_PG_WI;
            end
            ST_PG_WI: begin
                // Swap, first half, and read the output entry.
                n_sj = i_box_rd;
                n_t  = r_si + i_box_rd;
                o_box_req.wr_en   = 1'b1;
                o_box_req.wr_addr = r_first;
                o_box_req.wr_data = i_box_rd;
                o_box_req.rd_en   = 1'b1;
                o_box_req.rd_addr = r_si + i_box_rd;
                n_state = ST_PG_WJ;
            end
            ST_PG_WJ: begin
                // Swap, second half; hold until the output register is free.
                o_box_req.wr_en   = 1'b1;
                o_box_req.wr_addr = r_second;
                o_box_req.wr_data = r_si;
                if (i_out_free) begin
                    o_stat.done = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_first     <= '0;
            r_second    <= '0;
            r_kidx      <= '0;
            r_key_count <= '0;
            r_scheduled <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_second    <= n_second;
            r_kidx      <= n_kidx;
            r_key_count <= n_key_count;
            r_scheduled <= n_scheduled;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_si   <= n_si;
        r_sj   <= n_sj;
        r_t    <= n_t;
        r_data <= n_data;
    end

    // The key length never passes its limit.
    a_key_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_count <= rc4bc_pkg::KEY_MAX)
        else $error("key length counter passed its limit");

    // The key index stays below the key length during the schedule.
    a_kidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KS_RD) |-> ({1'b0, r_kidx} < key_n))
        else $error("key index out of range during schedule");

    // A finished schedule leaves both pointers at zero and the key marked.
    a_sched_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KS_WJ && r_first == rc4bc_pkg::BOX_LAST) |=>
        (r_first == '0 && r_second == '0 && r_scheduled && r_state == ST_IDLE))
        else $error("schedule did not end cleanly");

    // A box clear never coincides with a box write.
    a_clear_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_box_req.clear |-> !o_box_req.wr_en)
        else $error("box clear collided with a write");

endmodule

// ===== rtl/core/rc4_byte_cipher_core.sv =====
`timescale 1ns / 1ps
// Invert, bit-pair swap and pass-through results are registered as the request is taken;
// RC4 requests run PG_RJ, PG_WI, PG_WJ; a new one stalls until the result is registered.
// A key byte is written as it is taken; the last adds the key schedule over all 256 entries.
// The box memory has one write port, so the two swap writes of a byte go in separate states.
// Reset (synchronous, active low): mode RC4, box all zeros, pointers and key length zero.
// ----------------------------------------------------------------------------
// rc4_byte_cipher_core
// Byte cipher with invert, bit-pair swap, pass-through and RC4 keystream XOR
// modes, key loading and key schedule, with an output register toward the
// consumer.
module rc4_byte_cipher_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic [rc4bc_pkg::BYTE_W-1:0]        i_data_byte,
    input  logic                                i_key_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [rc4bc_pkg::BYTE_W-1:0]        o_out_byte,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_cipher_mode
);

    logic [1:0] r_mode;
    logic r_out_valid;
    logic [rc4bc_pkg::BYTE_W-1:0] r_out_byte;

    logic in_acc;
    logic out_free;
    logic direct_load;
    logic [rc4bc_pkg::BYTE_W-1:0] direct_byte;

    rc4bc_pkg::t_ctrl_cmd  ctrl_cmd;
    rc4bc_pkg::t_ctrl_stat ctrl_stat;
    rc4bc_pkg::t_box_req   box_req;
    rc4bc_pkg::t_key_req   key_req;
    logic [rc4bc_pkg::BYTE_W-1:0] box_rd;
    logic [rc4bc_pkg::BYTE_W-1:0] key_rd;

    // Request handshake: take a request when the sequencer is idle and the
    // output register can take a result.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = ctrl_stat.busy || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Mode register; writes are taken at any time.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rc4bc_pkg::MODE_RESET;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_cipher_mode;
        end
    end

    // Dispatch of requests to the sequencer.
    assign ctrl_cmd.key_start  = in_acc && (i_command == rc4bc_pkg::CMD_KEY);
    assign ctrl_cmd.prga_start = in_acc && (i_command == rc4bc_pkg::CMD_DATA)
                                 && (r_mode == rc4bc_pkg::MODE_RC4);
    assign ctrl_cmd.key_last   = i_key_last;
    assign ctrl_cmd.data_byte  = i_data_byte;

    // Modes without keystream finish in the request cycle.
    assign direct_load = in_acc && (i_command == rc4bc_pkg::CMD_DATA)
                         && (r_mode != rc4bc_pkg::MODE_RC4);
    always_comb begin
        case (r_mode)
            rc4bc_pkg::MODE_INVERT: direct_byte = ~i_data_byte;
            rc4bc_pkg::MODE_SWAP:   direct_byte = rc4bc_pkg::f_swap_pairs(i_data_byte);
            default:                direct_byte = i_data_byte;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (direct_load || ctrl_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (direct_load) begin
            r_out_byte <= direct_byte;
        end else if (ctrl_stat.done) begin
            r_out_byte <= ctrl_stat.out_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

    // Sequencer and its two memories.
    rc4bc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ctrl_cmd),
        .i_out_free (out_free),
        .i_box_rd   (box_rd),
        .i_key_rd   (key_rd),
        .o_box_req  (box_req),
        .o_key_req  (key_req),
        .o_stat     (ctrl_stat)
    );

    rc4bc_box_mem u_box_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (box_req),
        .o_rd_data (box_rd)
    );

    rc4bc_key_mem u_key_mem (
        .i_clk     (i_clk),
        .i_req     (key_req),
        .o_rd_data (key_rd)
    );

endmodule

// ===== verif/rc4_byte_cipher_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_byte_cipher_core_test
// Self-checking bench for the RC4 byte cipher core. A directed table covers
// every cipher mode, the zero keystream before any key and key replacement.
// Random phases of key loads and data bytes follow, one with an overlong key.
// Each data request is predicted by a local model of the key schedule and
// keystream, and every result is compared in order. Both sides idle in bursts.
// ----------------------------------------------------------------------------
module rc4_byte_cipher_core_test;

    localparam int unsigned CLK_HALF_NS  = 10;
    localparam int unsigned RESET_CYCLES = 9;
    localparam int unsigned RAND_ITEMS   = 450;
    // One full key schedule with margin; the core may still be busy after the last result.
    localparam int unsigned DRAIN_CYCLES = 1100;
    localparam int unsigned QUIET_TAIL   = 70;
    localparam int unsigned REPORT_MAX   = 10;
    localparam int unsigned LIMIT_NS     = 12_000_000;
    // The register field allows a fourth code, which passes data through.
    localparam logic [1:0]  MODE_PASS    = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        cmd;
        logic [7:0]  data;
        logic        last;
        logic [1:0]  mode;
        bit          typed;
        logic [7:0]  result;
    } t_stim_row;

    // Block ports.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_command = rc4bc_pkg::CMD_DATA;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_key_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_cipher_mode = rc4bc_pkg::MODE_RESET;

    // Local copy of the cipher state.
    logic [7:0]  sbox [256];
    logic [7:0]  key_bytes [256];
    logic [7:0]  ptr_i;
    logic [7:0]  ptr_j;
    logic [8:0]  key_len;
    logic        key_ready;
    logic [1:0]  mode_reg;

    // Cipher bytes still owed by the core, oldest first.
    logic [7:0]  expected_bytes [$];
    logic [7:0]  want_byte;
    t_stim_row   dir_rows [$];

    int unsigned fail_count = 0;
    int unsigned items_sent = 0;
    int unsigned calm_left = 0;
    int unsigned hold_left = 0;
    bit          quiet = 1'b0;

    rc4_byte_cipher_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_data_byte       (i_data_byte),
        .i_key_last        (i_key_last),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_byte        (o_out_byte),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_cipher_mode (i_cfg_cipher_mode)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Cipher state after reset: empty box, no key, RC4 mode.
    task automatic reset_cipher_state();
        for (int a = 0; a < 256; a++) begin
            sbox[a] = 8'h00;
            key_bytes[a] = 8'h00;
        end
        ptr_i = 8'h00;
        ptr_j = 8'h00;
        key_len = 9'd0;
        key_ready = 1'b0;
        mode_reg = rc4bc_pkg::MODE_RESET;
    endtask

    // Standard RC4 key schedule over the bytes loaded for the current key.
    task automatic run_key_schedule();
        int unsigned n;
        logic [7:0] j;
        logic [7:0] t;
        n = (key_len == 9'd0) ? 1 : int'(key_len);
        for (int a = 0; a < 256; a++) sbox[a] = 8'(a);
        j = 8'h00;
        for (int a = 0; a < 256; a++) begin
            j = j + key_bytes[a % n] + sbox[a];
            t = sbox[a];
            sbox[a] = sbox[j];
            sbox[j] = t;
        end
        ptr_i = 8'h00;
        ptr_j = 8'h00;
        key_ready = 1'b1;
    endtask

    // Next keystream byte; advances the pointers and swaps two entries.
    task automatic next_keystream(output logic [7:0] ks);
        logic [7:0] t;
        logic [7:0] idx;
        ptr_i = ptr_i + 8'd1;
        ptr_j = ptr_j + sbox[ptr_i];
        t = sbox[ptr_i];
        sbox[ptr_i] = sbox[ptr_j];
        sbox[ptr_j] = t;
        idx = sbox[ptr_i] + sbox[ptr_j];
        ks = sbox[idx];
    endtask

    // Applies one accepted request to the local state and yields its cipher byte, if any.
    task automatic cipher_step(input logic cmd, input logic [7:0] din, input logic last,
                               output bit has_out, output logic [7:0] dout);
        logic [7:0] ks;
        has_out = 1'b0;
        dout = 8'h00;
        if (cmd == rc4bc_pkg::CMD_KEY) begin
            // The first key byte after a schedule begins a new key.
            if (key_ready) begin
                key_len = 9'd0;
                key_ready = 1'b0;
            end
            if (key_len < rc4bc_pkg::KEY_MAX) begin
                key_bytes[key_len[7:0]] = din;
                key_len = key_len + 9'd1;
            end
            if (last) run_key_schedule();
        end else begin
            has_out = 1'b1;
            case (mode_reg)
                rc4bc_pkg::MODE_INVERT: dout = ~din;
                rc4bc_pkg::MODE_SWAP: begin
                    dout = {din[6], din[7], din[4], din[5], din[2], din[3], din[0], din[1]};
                end
                rc4bc_pkg::MODE_RC4: begin
                    next_keystream(ks);
                    dout = din ^ ks;
                end
                default: dout = din;
            endcase
        end
    endtask

    // Drives one request, waits for its acceptance and records what it should produce.
    task automatic send_request(input logic cmd, input logic [7:0] din, input logic last,
                                input bit typed, input logic [7:0] typed_byte);
        bit has_out;
        logic [7:0] pred;
        bit ignored;
        int unsigned gap;
        if (!quiet && calm_left == 0 && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            calm_left = $urandom_range(0, 24);
        end else if (calm_left != 0) begin
            calm_left--;
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_data_byte <= din;
        i_key_last  <= last;
        // Inputs only move at rising edges, so the value at the falling edge is what the
        // next rising edge sees.
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        ignored = (cmd == rc4bc_pkg::CMD_KEY) && !key_ready
                  && (key_len == rc4bc_pkg::KEY_MAX);
        cipher_step(cmd, din, last, has_out, pred);
        if (has_out) expected_bytes.push_back(typed ? typed_byte : pred);
        if (!ignored) items_sent++;
    endtask

    // Stops the input side, lets every owed result arrive and any key schedule finish.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes the cipher mode register through its own request channel.
    task automatic write_mode(input logic [1:0] m);
        i_cfg_valid       <= 1'b1;
        i_cfg_cipher_mode <= m;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        mode_reg = m;
    endtask

    task automatic send_key(input int unsigned len, input bit close);
        for (int unsigned k = 0; k < len; k++) begin
            send_request(rc4bc_pkg::CMD_KEY, 8'($urandom_range(0, 255)),
                         close && (k == len - 1), 1'b0, 8'h00);
        end
    endtask

    task automatic send_data_burst(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            send_request(rc4bc_pkg::CMD_DATA, 8'($urandom_range(0, 255)),
                         $urandom_range(0, 7) == 0, 1'b0, 8'h00);
        end
    endtask

    function automatic t_stim_row item_row(input logic cmd, input logic [7:0] d,
                                           input logic last, input bit typed,
                                           input logic [7:0] r);
        t_stim_row row;
        row.kind = ROW_ITEM;
        row.cmd = cmd;
        row.data = d;
        row.last = last;
        row.mode = rc4bc_pkg::MODE_RESET;
        row.typed = typed;
        row.result = r;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input logic [1:0] m);
        t_stim_row row;
        row = item_row(rc4bc_pkg::CMD_DATA, 8'h00, 1'b0, 1'b0, 8'h00);
        row.kind = ROW_CFG;
        row.mode = m;
        return row;
    endfunction

    // Consumer stall: random bursts, long free stretches, none in the quiet tail.
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
            hold_left <= 0;
        end else if (hold_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                hold_left <= $urandom_range(0, 16);
            end else begin
                i_out_stall <= 1'b0;
                hold_left <= $urandom_range(1, 40);
            end
        end else begin
            hold_left <= hold_left - 1;
        end
    end

    // Result checker: a result taken at the next rising edge is compared here.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX) begin
                    $display("%0t: out_byte 0x%02h arrived with nothing expected",
                             $time, o_out_byte);
                end
            end else begin
                want_byte = expected_bytes.pop_front();
                if (o_out_byte !== want_byte) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("%0t: out_byte expected 0x%02h, got 0x%02h",
                                 $time, want_byte, o_out_byte);
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin
        int unsigned phase;
        int unsigned n_seg;
        int unsigned seg_kind;
        logic [1:0]  phase_mode;

        reset_cipher_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Before any key the box is all zeros, so the keystream is zero.
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'h00, 1'b0, 1'b1, 8'h00));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'hFF, 1'b0, 1'b1, 8'hFF));
        // A key_last flag on a data byte has no effect.
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'h5A, 1'b1, 1'b1, 8'h5A));
        dir_rows.push_back(cfg_row(rc4bc_pkg::MODE_INVERT));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'h00, 1'b0, 1'b1, 8'hFF));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'hFF, 1'b0, 1'b1, 8'h00));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'h3C, 1'b0, 1'b1, 8'hC3));
        dir_rows.push_back(cfg_row(rc4bc_pkg::MODE_SWAP));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'hAA, 1'b0, 1'b1, 8'h55));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'h55, 1'b0, 1'b1, 8'hAA));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'hFF, 1'b0, 1'b1, 8'hFF));
        dir_rows.push_back(cfg_row(MODE_PASS));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'hA7, 1'b0, 1'b1, 8'hA7));
        dir_rows.push_back(cfg_row(rc4bc_pkg::MODE_RC4));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_KEY, 8'h00, 1'b0, 1'b0, 8'h00));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_KEY, 8'hFF, 1'b0, 1'b0, 8'h00));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_KEY, 8'h80, 1'b1, 1'b0, 8'h00));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'h00, 1'b0, 1'b0, 8'h00));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'hFF, 1'b0, 1'b0, 8'h00));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'h12, 1'b0, 1'b0, 8'h00));
        // A new key begins, but the box keeps its old contents until the schedule.
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_KEY, 8'h55, 1'b0, 1'b0, 8'h00));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'h00, 1'b0, 1'b0, 8'h00));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_KEY, 8'hAA, 1'b1, 1'b0, 8'h00));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'h5C, 1'b0, 1'b0, 8'h00));
        // Pass-through mode must leave the keystream where it was.
        dir_rows.push_back(cfg_row(MODE_PASS));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'h81, 1'b0, 1'b1, 8'h81));
        dir_rows.push_back(cfg_row(rc4bc_pkg::MODE_RC4));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'h00, 1'b0, 1'b0, 8'h00));
        // Single-byte key.
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_KEY, 8'h01, 1'b1, 1'b0, 8'h00));
        dir_rows.push_back(item_row(rc4bc_pkg::CMD_DATA, 8'hC3, 1'b0, 1'b0, 8'h00));

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                wait_idle();
                write_mode(dir_rows[r].mode);
            end else begin
                send_request(dir_rows[r].cmd, dir_rows[r].data, dir_rows[r].last,
                             dir_rows[r].typed, dir_rows[r].result);
            end
        end

        // Random phases, each under one cipher mode; many segments are complete keys followed by data.
        items_sent = 0;
        phase = 0;
        while (items_sent < RAND_ITEMS) begin
            case (phase)
                0: phase_mode = rc4bc_pkg::MODE_RC4;
                1: phase_mode = rc4bc_pkg::MODE_INVERT;
                2: phase_mode = rc4bc_pkg::MODE_RC4;
                3: phase_mode = rc4bc_pkg::MODE_SWAP;
                4: phase_mode = MODE_PASS;
                default: begin
                    case ($urandom_range(0, 5))
                        0: phase_mode = rc4bc_pkg::MODE_INVERT;
                        1: phase_mode = rc4bc_pkg::MODE_SWAP;
                        2: phase_mode = MODE_PASS;
                        default: phase_mode = rc4bc_pkg::MODE_RC4;
                    endcase
                end
            endcase
            if (items_sent + QUIET_TAIL >= RAND_ITEMS) quiet = 1'b1;
            wait_idle();
            write_mode(phase_mode);
            // Overlong key: bytes past the limit are dropped, the last one still schedules.
            if (phase == 2) begin
                send_key(256 + $urandom_range(1, 4), 1'b1);
                send_data_burst($urandom_range(8, 20));
            end
            n_seg = $urandom_range(2, 6);
            for (int unsigned s = 0; s < n_seg; s++) begin
                if (items_sent + QUIET_TAIL >= RAND_ITEMS) quiet = 1'b1;
                seg_kind = $urandom_range(0, 9);
                if (seg_kind <= 4) begin
                    send_key($urandom_range(1, 16), 1'b1);
                    send_data_burst($urandom_range(1, 24));
                end else if (seg_kind == 5) begin
                    // Key left unfinished: the previous box stays in use.
                    send_key($urandom_range(1, 4), 1'b0);
                    send_data_burst($urandom_range(1, 12));
                end else if (seg_kind == 6) begin
                    for (int unsigned k = 0; k < 6; k++) begin
                        send_request(rc4bc_pkg::CMD_DATA, 8'($urandom_range(0, 255)), 1'b1,
                                     1'b0, 8'h00);
                    end
                end else if (seg_kind == 7) begin
                    repeat ($urandom_range(1, 10)) begin
                        send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                     1'($urandom_range(0, 1)), 1'b0, 8'h00);
                    end
                end else begin
                    send_data_burst($urandom_range(4, 24));
                end
            end
            phase++;
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("** rc4_byte_cipher_core: PASSED **");
        end else begin
            $display("** rc4_byte_cipher_core: FAILED **");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #(LIMIT_NS);
        $display("** rc4_byte_cipher_core: FAILED **");
        $finish;
    end

endmodule
